[design/swsp_pkg.sv]
package swsp_pkg;

  localparam int InDataW  = 56;
  localparam int OutDataW = 48;
  localparam int OutUserW = 2;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  localparam logic [1:0] RegSpeedScale    = 2'd0;
  localparam logic [1:0] RegTicksPerDegree = 2'd1;
  localparam logic [1:0] RegStopSpeed     = 2'd2;
  localparam logic [1:0] RegHoldWindow    = 2'd3;

  localparam logic [15:0] SpeedScaleRst = 16'd2048;
  localparam logic [15:0] TicksPerDegRst = 16'd18637;
  localparam logic [13:0] StopSpeedRst  = 14'd25;
  localparam logic [15:0] HoldWindowRst = 16'd5;

  // One turn is TurnDiv << (frac + 3) angle units.
  localparam int TurnDiv = 45;

endpackage

[design/swerve_module_setpoint_optimizer_unit.sv]
// Swerve module setpoint optimizer. Each item carries a requested wheel speed, a requested
// heading and the measured unwrapped module angle; the block moves the heading by whole
// turns to within 180 degrees of the current angle, flips it by 180 degrees and reverses
// the drive when the remaining turn exceeds 90 degrees, and returns a saturated Q1.15 drive
// fraction, a negated steering setpoint in encoder ticks, a run flag and a reversed flag.
// A slow request whose setpoint stays inside the hold window of the last setpoint gives a
// zero drive, repeats the last setpoint and clears the run flag. The block takes one item
// per cycle unless the output stalls, passing each item through an input register, a
// turn-modulo stage built on a reciprocal multiply, a wrap and flip stage, a stage with
// the two scaling multipliers, a rounding and saturation stage, and the output register,
// where the hold test against the last setpoint is made. Each stage holds its item only
// while the next is full and stalled, so input is taken while any stage is empty. The user
// writes configuration registers via the APB port only while idle; the block does not check.
module swerve_module_setpoint_optimizer_unit #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // desired_speed[14:0], desired_angle[29:15], current_angle[53:30], zero pad
  input  logic [swsp_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // speed_fraction[15:0], steer_setpoint[47:16]
  output logic [swsp_pkg::OutDataW-1:0]  m_axis_tdata,
  // motors_run[0], reversed[1]
  output logic [swsp_pkg::OutUserW-1:0]  m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swsp_pkg::AddrW-1:0]     paddr,
  input  logic [swsp_pkg::DataW-1:0]     pwdata,
  output logic [swsp_pkg::DataW-1:0]     prdata,
  output logic                           pready
);
  import swsp_pkg::*;

  localparam int Lw  = ANGLE_FRAC_BITS + 3;
  localparam int Dw  = 25;
  localparam int Nw  = Dw - Lw;
  localparam int Sh  = Nw + 6;
  localparam int Qw  = Nw - 5;
  localparam int Pw  = 2 * Nw + 1;
  localparam int DLw = ANGLE_FRAC_BITS + 10;
  localparam int FullI    = 360 << ANGLE_FRAC_BITS;
  localparam int HalfI    = 180 << ANGLE_FRAC_BITS;
  localparam int QuarterI = 90 << ANGLE_FRAC_BITS;
  localparam int OffsetI  = FullI * (((1 << 23) + (1 << 14) + FullI - 1) / FullI);
  localparam longint MultL = ((longint'(1) << Sh) + TurnDiv - 1) / TurnDiv;
  localparam logic [Nw:0] Mult = (Nw + 1)'(MultL);
  localparam logic signed [DLw-1:0] Full       = DLw'(FullI);
  localparam logic signed [DLw-1:0] Half       = DLw'(HalfI);
  localparam logic signed [DLw-1:0] Quarter    = DLw'(QuarterI);
  localparam logic signed [DLw-1:0] NegQuarter = -DLw'(QuarterI);
  localparam logic signed [43:0] RoundHalf = 44'(longint'(1) << (ANGLE_FRAC_BITS + 7));
  localparam logic signed [43:0] SpMax = 44'sd2147483647;
  localparam logic signed [43:0] SpMin = -44'sd2147483648;
  localparam logic signed [33:0] FrMax = 34'sd32767;
  localparam logic signed [33:0] FrMin = -34'sd32767;

  // Configuration registers.
  logic [15:0] speed_scale_q, tpd_q, hold_window_q;
  logic [13:0] stop_speed_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_scale_q <= SpeedScaleRst;
      tpd_q         <= TicksPerDegRst;
      stop_speed_q  <= StopSpeedRst;
      hold_window_q <= HoldWindowRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegSpeedScale:     speed_scale_q <= pwdata[15:0];
        RegTicksPerDegree: tpd_q         <= pwdata[15:0];
        RegStopSpeed:      stop_speed_q  <= pwdata[13:0];
        RegHoldWindow:     hold_window_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSpeedScale:     prdata = {16'd0, speed_scale_q};
      RegTicksPerDegree: prdata = {16'd0, tpd_q};
      RegStopSpeed:      prdata = {18'd0, stop_speed_q};
      RegHoldWindow:     prdata = {16'd0, hold_window_q};
      default:           prdata = '0;
    endcase
  end

  // Pipeline occupancy and advance chain.
  logic [5:0] vld_q;
  logic [6:0] adv;

  always_comb begin
    adv[6] = m_axis_tready;
    for (int k = 5; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < 6; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic signed [14:0] spd0_q, des0_q;
  logic signed [23:0] cur0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      spd0_q <= s_axis_tdata[14:0];
      des0_q <= s_axis_tdata[29:15];
      cur0_q <= s_axis_tdata[53:30];
    end
  end

  // Stage 1: offset difference and quotient of its upper part by TurnDiv.
  logic signed [Dw-1:0] diff1;
  logic [Dw-1:0]        dp1;
  logic [Pw-1:0]        prod1;
  logic [Nw-1:0]        hi1_q;
  logic [Lw-1:0]        lo1_q;
  logic [Qw-1:0]        q1_q;
  logic signed [14:0]   spd1_q;
  logic signed [23:0]   cur1_q;

  assign diff1 = Dw'(des0_q) - Dw'(cur0_q);
  assign dp1   = Dw'($unsigned(diff1) + Dw'(OffsetI));
  assign prod1 = Pw'(dp1[Dw-1:Lw]) * Pw'(Mult);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      hi1_q  <= dp1[Dw-1:Lw];
      lo1_q  <= dp1[Lw-1:0];
      q1_q   <= prod1[Pw-1:Sh];
      spd1_q <= spd0_q;
      cur1_q <= cur0_q;
    end
  end

  // Stage 2: wrap into one half turn either way, then flip past a quarter turn.
  logic [Nw-1:0]         q45;
  logic [5:0]            rem2;
  logic signed [DLw-1:0] dl0, dw2, df2;
  logic                  flip2;
  logic signed [24:0]    tgt2_q;
  logic signed [15:0]    spd2_q;
  logic                  rev2_q;

  assign q45  = Nw'(q1_q) * Nw'(TurnDiv);
  assign rem2 = 6'(hi1_q - q45);
  assign dl0  = $signed({1'b0, rem2, lo1_q});
  assign dw2  = (dl0 > Half) ? dl0 - Full : dl0;
  assign flip2 = (dw2 > Quarter) || (dw2 < NegQuarter);
  assign df2  = (dw2 > Quarter) ? dw2 - Half : ((dw2 < NegQuarter) ? dw2 + Half : dw2);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      tgt2_q <= 25'(cur1_q) + 25'(df2);
      spd2_q <= flip2 ? -16'(spd1_q) : 16'(spd1_q);
      rev2_q <= flip2;
    end
  end

  // Stage 3: scaling multipliers.
  logic [15:0]        mag3;
  logic signed [32:0] fprod3_q;
  logic signed [41:0] sprod3_q;
  logic               slow3_q, rev3_q;

  assign mag3 = spd2_q[15] ? 16'(-spd2_q) : 16'(spd2_q);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      fprod3_q <= 33'(spd2_q) * 33'($signed({1'b0, speed_scale_q}));
      sprod3_q <= 42'(tgt2_q) * 42'($signed({1'b0, tpd_q}));
      slow3_q  <= mag3 < {2'b00, stop_speed_q};
      rev3_q   <= rev2_q;
    end
  end

  // Stage 4: round half up and saturate.
  logic signed [33:0] fs4;
  logic signed [43:0] sn4, ss4;
  logic signed [15:0] frac4_q;
  logic signed [31:0] sp4_q;
  logic               slow4_q, rev4_q;

  assign fs4 = (34'(fprod3_q) + 34'sd1) >>> 1;
  assign sn4 = 44'sd0 - 44'(sprod3_q) + RoundHalf;
  assign ss4 = sn4 >>> (ANGLE_FRAC_BITS + 8);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      frac4_q <= (fs4 > FrMax) ? 16'sd32767 : ((fs4 < FrMin) ? -16'sd32767 : 16'(fs4));
      sp4_q   <= (ss4 > SpMax) ? 32'(SpMax) : ((ss4 < SpMin) ? 32'(SpMin) : 32'(ss4));
      slow4_q <= slow3_q;
      rev4_q  <= rev3_q;
    end
  end

  // Stage 5: hold test and output register.
  logic signed [31:0] last_q;
  logic signed [32:0] dif5;
  logic [32:0]        adif5;
  logic               hold5;
  logic signed [15:0] frac_q;
  logic signed [31:0] sp_q;
  logic               run_q, rev_q;

  assign dif5  = 33'(last_q) - 33'(sp4_q);
  assign adif5 = dif5[32] ? $unsigned(-dif5) : $unsigned(dif5);
  assign hold5 = slow4_q && (adif5 < {17'd0, hold_window_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (adv[5] && vld_q[4] && !hold5) begin
      last_q <= sp4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      frac_q <= hold5 ? 16'sd0 : frac4_q;
      sp_q   <= hold5 ? last_q : sp4_q;
      run_q  <= !hold5;
      rev_q  <= rev4_q;
    end
  end

  assign m_axis_tdata = {sp_q, frac_q};
  assign m_axis_tuser = {rev_q, run_q};

  a_last_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv[5] && vld_q[4]) |=> $stable(last_q))
    else $error("last setpoint changed without a result load");

  a_out_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sp_q == last_q))
    else $error("delivered setpoint differs from the stored last setpoint");

  a_hold_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !run_q) |-> (frac_q == 16'sd0))
    else $error("held item carries a nonzero drive fraction");

  a_frac_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (frac_q != -16'sd32768))
    else $error("drive fraction outside its saturated range");

endmodule
